>>> rtl/cpu_bus_cycle_sequencer_macros.svh
// ----------------------------------------------------------------------------
// cpu_bus_cycle_sequencer_macros
// assertion helpers for the bus cycle sequencer, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef CPU_BUS_CYCLE_SEQUENCER_MACROS_SVH
`define CPU_BUS_CYCLE_SEQUENCER_MACROS_SVH

// property that must hold at every edge
`define CBCS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication with overlapping consequent
`define CBCS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle
`define CBCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cbcs_pkg.sv
// ----------------------------------------------------------------------------
// cbcs_pkg
// codes, widths and helper types for the bus cycle sequencer
// ----------------------------------------------------------------------------
package cbcs_pkg;

    localparam int KIND_W  = 3;
    localparam int PHASE_W = 3;
    localparam int TERM_W  = 2;
    localparam int CNT_W   = 16;
    localparam int BEAT_W  = 5;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 48;

    localparam int BURST_LEN_DEF = 4;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_BEGIN = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RMC   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BREQ  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BACK  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TERM  = 3'd5;

    // bus states
    localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_S0   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_S1   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_S2   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_S3   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_S4   = 3'd5;
    localparam logic [PHASE_W-1:0] PH_S5   = 3'd6;

    // termination codes
    localparam logic [TERM_W-1:0] TERM_NONE  = 2'd0;
    localparam logic [TERM_W-1:0] TERM_ASYNC = 2'd1;
    localparam logic [TERM_W-1:0] TERM_SYNC  = 2'd2;
    localparam logic [TERM_W-1:0] TERM_BERR  = 2'd3;

    typedef struct packed {
        logic ecs;
        logic ocs;
        logic as_n;
        logic ds;
        logic dben;
    } strobes_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
    endfunction

endpackage

>>> rtl/cpu_bus_cycle_sequencer.sv
// ----------------------------------------------------------------------------
// cpu_bus_cycle_sequencer
// external bus cycle state machine driven one bus event per word
// ----------------------------------------------------------------------------
// Every input word is one bus event (begin, clock tick, rmc level, burst
// request, burst ack, termination). The event is applied in the cycle it is
// accepted and the resulting bus levels and counters appear in the output
// register on the next clock. One word is taken every
// clock as long as the output register is empty or being drained in the same
// cycle; the only limit is that single output register.
module cpu_bus_cycle_sequencer #(
    parameter int BURST_LEN = cbcs_pkg::BURST_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // is_read, op_start, rmc_level, burst_ack, term_code[1:0], zero pad
    input  logic [cbcs_pkg::IN_W-1:0]    s_tdata,
    // kind[2:0]
    input  logic [cbcs_pkg::KIND_W-1:0]  s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // cycle_done, busy_res, finished, bus_state[2:0], ecs_out, ocs_out,
    // addr_strobe, data_strobe, buffer_enable, burst_request,
    // wait_count[15:0], clock_count[15:0], zero pad
    output logic [cbcs_pkg::OUT_W-1:0]   m_tdata
);

    localparam logic [cbcs_pkg::BEAT_W:0] BURST_LEN_C = (cbcs_pkg::BEAT_W+1)'(BURST_LEN);

    logic [cbcs_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                         dir_read_reg, dir_read_next;
    logic                         rmc_held_reg, rmc_held_next;
    logic [cbcs_pkg::TERM_W-1:0]  term_reg, term_next;
    logic [cbcs_pkg::CNT_W-1:0]   clocks_reg, clocks_next;
    logic [cbcs_pkg::CNT_W-1:0]   waits_reg, waits_next;
    logic                         active_reg, active_next;
    logic                         complete_reg, complete_next;
    logic                         to_s4_reg, to_s4_next;
    logic                         req_reg, req_next;
    logic                         ack_reg, ack_next;
    logic                         in_burst_reg, in_burst_next;
    logic [cbcs_pkg::BEAT_W-1:0]  beats_reg, beats_next;
    cbcs_pkg::strobes_t           strb_reg, strb_next;

    logic                         m_tvalid_reg;
    logic [cbcs_pkg::OUT_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                         accept;
    logic                         done;
    logic                         finish;
    logic [cbcs_pkg::BEAT_W-1:0]  beat_inc;
    logic [cbcs_pkg::KIND_W-1:0]  kind;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign kind     = s_tuser;
    assign beat_inc = beats_reg + cbcs_pkg::BEAT_W'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        dir_read_next = dir_read_reg;
        rmc_held_next = rmc_held_reg;
        term_next     = term_reg;
        clocks_next   = clocks_reg;
        waits_next    = waits_reg;
        active_next   = active_reg;
        complete_next = complete_reg;
        to_s4_next    = to_s4_reg;
        req_next      = req_reg;
        ack_next      = ack_reg;
        in_burst_next = in_burst_reg;
        beats_next    = beats_reg;
        strb_next     = strb_reg;
        done          = 1'b0;
        finish        = 1'b0;

        unique case (kind)
            cbcs_pkg::KIND_BEGIN:
            begin
                dir_read_next  = s_tdata[0];
                phase_next     = cbcs_pkg::PH_IDLE;
                term_next      = cbcs_pkg::TERM_NONE;
                clocks_next    = '0;
                waits_next     = '0;
                active_next    = 1'b1;
                complete_next  = 1'b0;
                to_s4_next     = 1'b0;
                req_next       = 1'b0;
                ack_next       = 1'b0;
                in_burst_next  = 1'b0;
                beats_next     = '0;
                strb_next      = '0;
                strb_next.ocs  = s_tdata[1];
            end
            cbcs_pkg::KIND_TICK:
            begin
                if (active_reg)
                begin
                    clocks_next = cbcs_pkg::sat_inc(clocks_reg);
                    priority if (phase_reg == cbcs_pkg::PH_IDLE)
                    begin
                        // through S0 into S1
                        phase_next     = cbcs_pkg::PH_S1;
                        strb_next.ecs  = 1'b0;
                        strb_next.ocs  = 1'b0;
                        strb_next.as_n = 1'b1;
                        strb_next.ds   = dir_read_reg;
                        strb_next.dben = !dir_read_reg;
                    end
                    else if (to_s4_reg)
                    begin
                        finish = 1'b1;
                    end
                    else if (in_burst_reg)
                    begin
                        priority if (term_reg == cbcs_pkg::TERM_BERR)
                        begin
                            finish = 1'b1;
                        end
                        else if (term_reg != cbcs_pkg::TERM_SYNC)
                        begin
                            waits_next = cbcs_pkg::sat_inc(waits_reg);
                        end
                        else
                        begin
                            beats_next = beat_inc;
                            // drop the request before the last word
                            if ({1'b0, beat_inc} + 1'b1 >= BURST_LEN_C)
                            begin
                                req_next = 1'b0;
                            end
                            if ({1'b0, beat_inc} >= BURST_LEN_C)
                            begin
                                finish = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        // through S2 into S3
                        phase_next     = cbcs_pkg::PH_S3;
                        strb_next.as_n = 1'b1;
                        strb_next.ds   = 1'b1;
                        strb_next.dben = 1'b1;
                        priority if (term_reg == cbcs_pkg::TERM_NONE)
                        begin
                            waits_next = cbcs_pkg::sat_inc(waits_reg);
                        end
                        else if (term_reg == cbcs_pkg::TERM_SYNC && req_reg && ack_reg)
                        begin
                            beats_next    = cbcs_pkg::BEAT_W'(1);
                            in_burst_next = 1'b1;
                        end
                        else if (term_reg == cbcs_pkg::TERM_SYNC ||
                                 term_reg == cbcs_pkg::TERM_BERR)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            to_s4_next = 1'b1;
                        end
                    end
                end
            end
            cbcs_pkg::KIND_RMC:
            begin
                rmc_held_next = s_tdata[2];
            end
            cbcs_pkg::KIND_BREQ:
            begin
                if (!rmc_held_reg)
                begin
                    req_next = 1'b1;
                end
            end
            cbcs_pkg::KIND_BACK:
            begin
                ack_next = s_tdata[3];
            end
            cbcs_pkg::KIND_TERM:
            begin
                if (active_reg)
                begin
                    term_next = s_tdata[5:4];
                end
            end
            default:
            begin
            end
        endcase

        // cycle ends at S5
        if (finish)
        begin
            phase_next     = cbcs_pkg::PH_S5;
            strb_next.as_n = 1'b0;
            strb_next.ds   = 1'b0;
            strb_next.dben = !dir_read_reg;
            active_next    = 1'b0;
            complete_next  = 1'b1;
            in_burst_next  = 1'b0;
            done           = 1'b1;
        end

        m_tdata_next = {4'b0000, clocks_next, waits_next, req_next,
                        strb_next.dben, strb_next.ds, strb_next.as_n,
                        strb_next.ocs, strb_next.ecs, phase_next,
                        complete_next, active_next, done};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= cbcs_pkg::PH_IDLE;
            dir_read_reg <= 1'b0;
            rmc_held_reg <= 1'b0;
            term_reg     <= cbcs_pkg::TERM_NONE;
            clocks_reg   <= '0;
            waits_reg    <= '0;
            active_reg   <= 1'b0;
            complete_reg <= 1'b0;
            to_s4_reg    <= 1'b0;
            req_reg      <= 1'b0;
            ack_reg      <= 1'b0;
            in_burst_reg <= 1'b0;
            beats_reg    <= '0;
            strb_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg    <= phase_next;
                dir_read_reg <= dir_read_next;
                rmc_held_reg <= rmc_held_next;
                term_reg     <= term_next;
                clocks_reg   <= clocks_next;
                waits_reg    <= waits_next;
                active_reg   <= active_next;
                complete_reg <= complete_next;
                to_s4_reg    <= to_s4_next;
                req_reg      <= req_next;
                ack_reg      <= ack_next;
                in_burst_reg <= in_burst_next;
                beats_reg    <= beats_next;
                strb_reg     <= strb_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

`include "cpu_bus_cycle_sequencer_macros.svh"

    `CBCS_ASSERT_ALWAYS(a_busy_xor_done, !(active_reg && complete_reg),
        "busy and finished together")
    `CBCS_ASSERT_IMPLY(a_burst_in_s3, in_burst_reg,
        active_reg && phase_reg == cbcs_pkg::PH_S3, "burst outside S3")
    `CBCS_ASSERT_ALWAYS(a_beats_bound, {1'b0, beats_reg} <= BURST_LEN_C,
        "burst beat count overrun")
    `CBCS_ASSERT_NEXT(a_done_idle, accept && done, !active_reg && complete_reg,
        "completion not recorded")

endmodule
